[rtl/rmth_pkg.sv]
package rmth_pkg;

    localparam int HEAP_DEPTH = 4096;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = 13;
    localparam logic [IW-1:0] INDEX_MAX = {IW{1'b1}};

    typedef struct packed {
        logic signed [31:0] sample;
        logic               first;
    } t_in;

    typedef struct packed {
        logic signed [31:0] median;
        logic [IW-1:0]      median_index;
        logic               overflow;
    } t_out;

    typedef enum logic [1:0] {
        HOP_PUSH,
        HOP_POP
    } t_hop;

    typedef struct packed {
        logic               start;
        t_hop               op;
        logic signed [31:0] value;
    } t_heap_cmd;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] top;
        logic [CW-1:0]      count;
    } t_heap_sts;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_PUSH_RD,
        HS_PUSH_WAIT,
        HS_PUSH_CMP,
        HS_POP_RD_LAST,
        HS_POP_WAIT_LAST,
        HS_POP_RD_C1,
        HS_POP_RD_C2,
        HS_POP_WAIT,
        HS_POP_CMP,
        HS_WRITE_FINAL
    } t_hstate;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_WAIT_PUSH,
        ST_POP,
        ST_WAIT_POP,
        ST_REPUSH,
        ST_WAIT_REPUSH,
        ST_OUT
    } t_state;

endpackage

[rtl/running_median_two_heaps_core.sv]
// channel  dir  payload  handshake
// in       in   t_in     i_valid / o_stall
// out      out  t_out    o_valid / i_stall
// a first item clears both heaps and registers itself as the result straight from idle
// a later item is pushed onto one heap and climbs it level by level
// every second item may pop the larger heap, sinking its last entry level by level, and push
// the old median on the other, before the next item is taken
// reset clears counts and control; heap contents need no clearing
// one result register; o_stall is high until the result is taken
module running_median_two_heaps_core import rmth_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_state             r_state, n_state;
    logic signed [31:0] r_median, n_median;
    logic               r_phase, n_phase;
    logic [IW-1:0]      r_emitted, n_emitted;
    logic               r_ovf, n_ovf;
    logic               r_dir, n_dir;
    logic               r_emit, n_emit;
    logic signed [31:0] r_sample, n_sample;
    logic               r_oval, n_oval;
    t_out               r_out, n_out;

    t_heap_cmd lo_cmd, up_cmd;
    t_heap_sts lo_sts, up_sts;
    logic      clr;
    logic      acc;

    rmth_heap u_lower (
        .i_clk, .i_rst_n, .i_is_upper(1'b0), .i_clear(clr),
        .i_cmd(lo_cmd), .o_sts(lo_sts)
    );

    rmth_heap u_upper (
        .i_clk, .i_rst_n, .i_is_upper(1'b1), .i_clear(clr),
        .i_cmd(up_cmd), .o_sts(up_sts)
    );

    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_median  <= '0;
            r_phase   <= 1'b0;
            r_emitted <= '0;
            r_ovf     <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_median  <= n_median;
            r_phase   <= n_phase;
            r_emitted <= n_emitted;
            r_ovf     <= n_ovf;
            r_oval    <= n_oval;
        end
        r_dir    <= n_dir;
        r_emit   <= n_emit;
        r_sample <= n_sample;
        r_out    <= n_out;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && !i_data.first) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH:        n_state = ST_WAIT_PUSH;
            ST_WAIT_PUSH: begin
                if (!lo_sts.busy && !up_sts.busy) begin
                    if (!r_emit) begin
                        n_state = ST_IDLE;
                    end else if (lo_sts.count == up_sts.count + CW'(2)
                              || up_sts.count == lo_sts.count + CW'(2)) begin
                        n_state = ST_POP;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_POP:         n_state = ST_WAIT_POP;
            ST_WAIT_POP: begin
                if (!lo_sts.busy && !up_sts.busy) begin
                    n_state = ST_REPUSH;
                end
            end
            ST_REPUSH:      n_state = ST_WAIT_REPUSH;
            ST_WAIT_REPUSH: begin
                if (!lo_sts.busy && !up_sts.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:         n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_median  = r_median;
        n_phase   = r_phase;
        n_emitted = r_emitted;
        n_ovf     = r_ovf;
        n_dir     = r_dir;
        n_emit    = r_emit;
        n_sample  = r_sample;
        n_oval    = r_oval && i_stall;
        n_out     = r_out;
        lo_cmd    = '{start: 1'b0, op: HOP_PUSH, value: r_sample};
        up_cmd    = '{start: 1'b0, op: HOP_PUSH, value: r_sample};
        clr       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_data.first) begin
                    clr       = 1'b1;
                    n_median  = i_data.sample;
                    n_phase   = 1'b0;
                    n_ovf     = 1'b0;
                    n_out     = '{median: i_data.sample, median_index: '0, overflow: 1'b0};
                    n_oval    = 1'b1;
                    n_emitted = IW'(1);
                end else if (acc) begin
                    n_sample = i_data.sample;
                    n_dir    = i_data.sample > r_median;
                    n_emit   = r_phase;
                    n_phase  = !r_phase;
                end
            end
            ST_PUSH: begin
                if (r_dir) begin
                    if (up_sts.count == CW'(HEAP_DEPTH)) n_ovf = 1'b1;
                    else up_cmd.start = 1'b1;
                end else begin
                    if (lo_sts.count == CW'(HEAP_DEPTH)) n_ovf = 1'b1;
                    else lo_cmd.start = 1'b1;
                end
            end
            ST_WAIT_POP: begin
                n_dir = lo_sts.count > up_sts.count;
            end
            ST_POP: begin
                if (lo_sts.count > up_sts.count) begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = HOP_POP;
                end else begin
                    up_cmd.start = 1'b1;
                    up_cmd.op    = HOP_POP;
                end
            end
            ST_REPUSH: begin
                if (r_dir) begin
                    up_cmd.start = 1'b1;
                    up_cmd.value = r_median;
                    n_median     = lo_sts.top;
                end else begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.value = r_median;
                    n_median     = up_sts.top;
                end
            end
            ST_OUT: begin
                n_out  = '{median: r_median, median_index: r_emitted, overflow: r_ovf};
                n_oval = 1'b1;
                if (r_emitted != INDEX_MAX) n_emitted = r_emitted + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE) || r_oval;
    assign o_valid = r_oval;
    assign o_data  = r_out;

endmodule

[rtl/rmth_heap.sv]
module rmth_heap import rmth_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_is_upper,
    input  logic      i_clear,
    input  t_heap_cmd i_cmd,
    output t_heap_sts o_sts
);

    logic signed [31:0] r_mem [HEAP_DEPTH];
    logic signed [31:0] r_rdata;

    t_hstate            r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW:0]        r_pos, n_pos;
    logic [CW:0]        r_child, n_child;
    logic signed [31:0] r_x, n_x;
    logic signed [31:0] r_c1, n_c1;
    logic signed [31:0] r_top, n_top;
    logic               r_has_c2, n_has_c2;

    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic signed [31:0] w_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic signed [31:0] cmp_a, cmp_b;
    logic               cmp_above;

    always_comb begin
        cmp_above = i_is_upper ? (cmp_a < cmp_b) : (cmp_a > cmp_b);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_child  <= n_child;
        r_x      <= n_x;
        r_c1     <= n_c1;
        r_top    <= n_top;
        r_has_c2 <= n_has_c2;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_child  = r_child;
        n_x      = r_x;
        n_c1     = r_c1;
        n_top    = r_top;
        n_has_c2 = r_has_c2;
        w_en     = 1'b0;
        w_addr   = '0;
        w_data   = r_x;
        rd_en    = 1'b0;
        rd_addr  = '0;
        cmp_a    = r_x;
        cmp_b    = r_rdata;
        case (r_state)
            HS_IDLE: begin
                if (i_clear) begin
                    n_count = '0;
                end else if (i_cmd.start) begin
                    if (i_cmd.op == HOP_PUSH) begin
                        n_x     = i_cmd.value;
                        n_count = r_count + 1'b1;
                        n_pos   = {1'b0, r_count + 1'b1};
                        n_state = HS_PUSH_RD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_count = r_count - 1'b1;
                        n_state = HS_POP_RD_LAST;
                    end
                end
            end
            HS_PUSH_RD: begin
                if (r_pos == {{CW{1'b0}}, 1'b1}) begin
                    n_state = HS_WRITE_FINAL;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'((r_pos >> 1) - 1'b1);
                    n_state = HS_PUSH_WAIT;
                end
            end
            HS_PUSH_WAIT: begin
                n_state = HS_PUSH_CMP;
            end
            HS_PUSH_CMP: begin
                if (cmp_above) begin
                    w_en    = 1'b1;
                    w_addr  = AW'(r_pos - 1'b1);
                    w_data  = r_rdata;
                    n_pos   = r_pos >> 1;
                    n_state = HS_PUSH_RD;
                end else begin
                    n_state = HS_WRITE_FINAL;
                end
            end
            HS_POP_RD_LAST: begin
                n_top   = r_rdata;
                rd_en   = 1'b1;
                rd_addr = AW'(r_count);
                n_state = HS_POP_WAIT_LAST;
            end
            HS_POP_WAIT_LAST: begin
                n_x     = r_rdata;
                n_child = (CW+1)'(2);
                n_state = HS_POP_RD_C1;
            end
            HS_POP_RD_C1: begin
                if (r_child > {1'b0, r_count}) begin
                    n_pos   = r_child >> 1;
                    n_state = HS_WRITE_FINAL;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(r_child - 1'b1);
                    n_has_c2 = r_child < {1'b0, r_count};
                    n_state  = HS_POP_RD_C2;
                end
            end
            HS_POP_RD_C2: begin
                n_c1 = r_rdata;
                if (r_has_c2) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_child);
                    n_state = HS_POP_WAIT;
                end else begin
                    n_state = HS_POP_CMP;
                end
            end
            HS_POP_WAIT: begin
                cmp_a = r_rdata;
                cmp_b = r_c1;
                if (cmp_above) begin
                    n_c1    = r_rdata;
                    n_child = r_child + 1'b1;
                end
                n_state = HS_POP_CMP;
            end
            HS_POP_CMP: begin
                cmp_a = r_x;
                cmp_b = r_c1;
                if (cmp_above) begin
                    n_pos   = r_child >> 1;
                    n_state = HS_WRITE_FINAL;
                end else begin
                    w_en    = 1'b1;
                    w_addr  = AW'((r_child >> 1) - 1'b1);
                    w_data  = r_c1;
                    n_child = {r_child[CW-1:0] & ~r_child[CW-1:0], 1'b0} | (r_child << 1);
                    n_state = HS_POP_RD_C1;
                end
            end
            HS_WRITE_FINAL: begin
                w_en    = 1'b1;
                w_addr  = AW'(r_pos - 1'b1);
                w_data  = r_x;
                n_state = HS_IDLE;
            end
            default: begin
                n_state = HS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sts.busy  = (r_state != HS_IDLE) || i_cmd.start;
        o_sts.top   = r_top;
        o_sts.count = r_count;
    end

endmodule

[bench/tb_running_median_two_heaps_core.sv]
module tb_running_median_two_heaps_core;
    import rmth_pkg::*;

    localparam int DEPTH = HEAP_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    running_median_two_heaps_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // predictor state
    logic signed [31:0] lo_heap [DEPTH];
    logic signed [31:0] hi_heap [DEPTH];
    int                 lo_cnt;
    int                 hi_cnt;
    logic signed [31:0] med_now;
    bit                 odd_phase;
    int                 med_seen;
    bit                 ovf_seen;

    t_out  median_queue[$];
    int    mismatch_count;
    int    cycle_count;
    int    items_sent;
    int    medians_checked;
    int    overflow_results;
    bit    hold_long;
    bit    calm;
    bit    sent_ok;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit ranks_above(bit upper, logic signed [31:0] a,
                                       logic signed [31:0] b);
        return upper ? (a < b) : (a > b);
    endfunction

    task automatic pred_push(bit upper, logic signed [31:0] x);
        int pos;
        if (upper) begin
            hi_cnt++;
            pos = hi_cnt;
            while (pos != 1 && ranks_above(1, x, hi_heap[(pos >> 1) - 1])) begin
                hi_heap[pos - 1] = hi_heap[(pos >> 1) - 1];
                pos >>= 1;
            end
            hi_heap[pos - 1] = x;
        end else begin
            lo_cnt++;
            pos = lo_cnt;
            while (pos != 1 && ranks_above(0, x, lo_heap[(pos >> 1) - 1])) begin
                lo_heap[pos - 1] = lo_heap[(pos >> 1) - 1];
                pos >>= 1;
            end
            lo_heap[pos - 1] = x;
        end
    endtask

    task automatic pred_pop(bit upper, output logic signed [31:0] top);
        logic signed [31:0] last;
        int child;
        int n;
        child = 2;
        if (upper) begin
            top = hi_heap[0];
            last = hi_heap[hi_cnt - 1];
            hi_cnt--;
            n = hi_cnt;
            while (child <= n) begin
                if (child < n && ranks_above(1, hi_heap[child], hi_heap[child - 1]))
                    child++;
                if (ranks_above(1, last, hi_heap[child - 1]))
                    break;
                hi_heap[(child >> 1) - 1] = hi_heap[child - 1];
                child <<= 1;
            end
            hi_heap[(child >> 1) - 1] = last;
        end else begin
            top = lo_heap[0];
            last = lo_heap[lo_cnt - 1];
            lo_cnt--;
            n = lo_cnt;
            while (child <= n) begin
                if (child < n && ranks_above(0, lo_heap[child], lo_heap[child - 1]))
                    child++;
                if (ranks_above(0, last, lo_heap[child - 1]))
                    break;
                lo_heap[(child >> 1) - 1] = lo_heap[child - 1];
                child <<= 1;
            end
            lo_heap[(child >> 1) - 1] = last;
        end
    endtask

    task automatic emit_median();
        t_out r;
        r.median = med_now;
        r.median_index = med_seen[IW-1:0];
        r.overflow = ovf_seen;
        median_queue.push_back(r);
        if (med_seen < int'(INDEX_MAX))
            med_seen++;
    endtask

    task automatic predict_median(t_in it);
        logic signed [31:0] m;
        if (it.first) begin
            lo_cnt = 0;
            hi_cnt = 0;
            med_now = it.sample;
            odd_phase = 0;
            med_seen = 0;
            ovf_seen = 0;
            emit_median();
            return;
        end
        if (it.sample > med_now) begin
            if (hi_cnt < DEPTH) pred_push(1, it.sample);
            else ovf_seen = 1;
        end else begin
            if (lo_cnt < DEPTH) pred_push(0, it.sample);
            else ovf_seen = 1;
        end
        odd_phase = ~odd_phase;
        if (odd_phase)
            return;
        if (lo_cnt == hi_cnt + 2) begin
            pred_pop(0, m);
            pred_push(1, med_now);
            med_now = m;
        end else if (hi_cnt == lo_cnt + 2) begin
            pred_pop(1, m);
            pred_push(0, med_now);
            med_now = m;
        end
        emit_median();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    // send one item, idling at random unless calm
    task automatic send_item(t_in it);
        while (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        sent_ok = 0;
        while (!sent_ok) begin
            @(posedge i_clk);
            sent_ok = i_valid && !o_stall;
            @(negedge i_clk);
        end
        predict_median(it);
        items_sent++;
    endtask

    // receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (hold_long)
            i_stall <= 1'b1;
        else if (calm)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < 31);
    end

    // result check
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (median_queue.size() == 0) begin
                report_mismatch("unexpected median", o_data.median, 0);
            end else begin
                want = median_queue.pop_front();
                medians_checked++;
                if (o_data.overflow) overflow_results++;
                if (o_data.median !== want.median)
                    report_mismatch("median", o_data.median, want.median);
                if (o_data.median_index !== want.median_index)
                    report_mismatch("median_index", 32'(o_data.median_index),
                                    32'(want.median_index));
                if (o_data.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_data.overflow),
                                    32'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    typedef struct {
        logic signed [31:0] sample;
        bit                 first;
        bit                 typed;
        logic signed [31:0] want_median;
        logic [IW-1:0]      want_index;
    } t_row;

    t_row dir_rows[] = '{
        // later item right after reset: empty sequence, median 0
        '{32'sd5,          0, 0, 0, 0},
        '{-32'sd3,         0, 1, 32'sd0, 0},
        '{32'h7fffffff,    1, 1, 32'h7fffffff, 0},
        '{32'h80000000,    1, 1, 32'h80000000, 0},
        '{32'h7fffffff,    0, 0, 0, 0},
        '{32'h7fffffff,    0, 0, 0, 0},
        '{32'h80000000,    0, 0, 0, 0},
        '{32'h80000000,    0, 0, 0, 0},
        '{32'sd0,          1, 1, 32'sd0, 0},
        '{32'sd0,          0, 0, 0, 0},
        '{32'sd0,          0, 0, 0, 0},
        '{-32'sd1,         0, 0, 0, 0},
        '{-32'sd2,         0, 0, 0, 0},
        '{32'sd10,         0, 0, 0, 0},
        '{32'sd20,         0, 0, 0, 0},
        '{32'sd30,         0, 0, 0, 0},
        '{32'sd40,         0, 0, 0, 0},
        '{32'h55555555,    0, 0, 0, 0},
        '{32'haaaaaaaa,    0, 0, 0, 0}
    };

    function automatic logic signed [31:0] rand_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(40)) - 20;
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    initial begin
        t_in it;
        int  len;
        int  mode;
        logic signed [31:0] bias;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;
        hold_long = 0;
        calm = 0;
        mismatch_count = 0;
        cycle_count = 0;
        items_sent = 0;
        medians_checked = 0;
        overflow_results = 0;
        lo_cnt = 0;
        hi_cnt = 0;
        med_now = 0;
        odd_phase = 0;
        med_seen = 0;
        ovf_seen = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            it.sample = dir_rows[k].sample;
            it.first  = dir_rows[k].first;
            send_item(it);
            if (dir_rows[k].typed) begin
                if (median_queue.size() == 0 ||
                    median_queue[$].median !== dir_rows[k].want_median ||
                    median_queue[$].median_index !== dir_rows[k].want_index)
                    report_mismatch("directed row", k, 0);
            end
        end

        // long receiver hold-off while items keep coming
        fork
            begin
                hold_long = 1;
                repeat (600) @(negedge i_clk);
                hold_long = 0;
            end
            begin
                it.first = 1;
                it.sample = $urandom();
                send_item(it);
                for (int j = 0; j < 30; j++) begin
                    it.first = 0;
                    it.sample = $urandom();
                    send_item(it);
                end
                i_valid <= 1'b0;
            end
        join

        // random sequences, skewed ones drive one heap deep
        while (items_sent < 590) begin
            len = $urandom_range(40, 2);
            mode = $urandom_range(2);
            calm = ($urandom_range(9) == 0);
            it.first = ($urandom_range(9) != 0);
            it.sample = rand_sample(mode);
            send_item(it);
            bias = $urandom_range(1) ? 32'sd1 : -32'sd1;
            for (int j = 0; j < len; j++) begin
                it.first = ($urandom_range(49) == 0);
                it.sample = ($urandom_range(3) == 0) ? bias * $signed($urandom_range(1000))
                                                      : rand_sample(mode);
                send_item(it);
            end
        end
        i_valid <= 1'b0;
        calm = 0;

        while (median_queue.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("sent %0d items, checked %0d medians (%0d with overflow flag)",
                 items_sent, medians_checked, overflow_results);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/rmth_pkg.sv
rtl/rmth_heap.sv
rtl/running_median_two_heaps_core.sv
bench/tb_running_median_two_heaps_core.sv
